// File: rtl/core/tcl_pkg.sv
package tcl_pkg;

   localparam int GUEST_ADDR_W = 32;
   localparam int CACHE_WORD_W = 21;
   localparam int ENTRY_W      = 21;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BUSY
   } tcl_state_type;

endpackage

// File: rtl/core/tcl_if.sv
interface tcl_req_if import tcl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    mode;
   logic [GUEST_ADDR_W-1:0] guest_address;
   logic [CACHE_WORD_W-1:0] cache_word;

   modport source (output valid, output mode, output guest_address, output cache_word,
                   input ready);
   modport sink   (input valid, input mode, input guest_address, input cache_word,
                   output ready);
endinterface

interface tcl_rsp_if import tcl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ENTRY_W-1:0]      entry_word;
   logic                    page_clear_needed;
   logic [GUEST_ADDR_W-1:0] recovered_address;

   modport source (output valid, output entry_word, output page_clear_needed,
                   output recovered_address, input ready);
   modport sink   (input valid, input entry_word, input page_clear_needed,
                   input recovered_address, output ready);
endinterface

// File: rtl/core/translation_cache_tag_lookup_unit.sv
// Tag lookup for a set-associative cache of translated guest code.
// req channel: mode 0 looks up guest_address, installs the tag round robin on a
// miss and returns entry_word (way,page,index) with page_clear_needed set on
// an install; mode 1 maps cache_word back to the guest address.
// rsp channel: one transaction per request, in request order.
// Timing: the page row (all way tags plus the victim pointer) is read from
// the tag and pointer memories at the accepting edge; the result is loaded
// into the output register once that register is free, and rsp.valid then rises.
// Throughput: one request per cycle while the output register is free; a miss
// writes the row back in the same cycle the next row is read, and a following
// request to the same page takes the written row from a forwarding register.
// Reset: a clearing pass writes zero to every page row; req.ready stays low
// until it ends.
// Stall: while rsp.ready is low a finished result is held in the output
// register; one more request may be accepted and waits with its row read.
module translation_cache_tag_lookup_unit import tcl_pkg::*; #(
   parameter int WAY_BITS   = 2,
   parameter int PAGE_BITS  = 9,
   parameter int INDEX_BITS = 10
) (
   input  logic      clock,
   input  logic      reset,
   tcl_req_if.sink   req,
   tcl_rsp_if.source rsp
);

   localparam int TAG_W     = GUEST_ADDR_W - 1 - INDEX_BITS;
   localparam int NUM_WAYS  = 1 << WAY_BITS;
   localparam int WB1       = (WAY_BITS > 0) ? WAY_BITS : 1;
   localparam int ROW_W     = NUM_WAYS * TAG_W;
   localparam int NUM_PAGES = 1 << PAGE_BITS;
   localparam int ENT_FW    = WB1 + PAGE_BITS + INDEX_BITS;
   localparam logic [WB1-1:0] WAY_MASK = WB1'(NUM_WAYS - 1);

   tcl_state_type state_ff, state_in;
   logic [PAGE_BITS-1:0] clr_ptr_ff, clr_ptr_in;

   // request held while its row is read
   logic                  mode_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [INDEX_BITS-1:0] index_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [WB1-1:0]        way_ff;

   logic                  fwd_ff, fwd_in;
   logic [ROW_W-1:0]      fwd_row_ff;
   logic [WB1-1:0]        fwd_vp_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0]      entry_ff, entry_in;
   logic                    clear_ff, clear_in;
   logic [GUEST_ADDR_W-1:0] addr_ff, addr_in;

   logic                  req_ready;
   logic                  accept;
   logic                  out_free;
   logic                  finish;
   logic                  lk_miss;
   logic [TAG_W-1:0]      req_tag;
   logic [INDEX_BITS-1:0] req_index;
   logic [PAGE_BITS-1:0]  req_page;
   logic [WB1-1:0]        req_way;
   logic [63:0]           cw_wide;

   logic                  mem_we;
   logic [PAGE_BITS-1:0]  mem_waddr;
   logic [ROW_W-1:0]      tag_wdata;
   logic [WB1-1:0]        vp_wdata;
   logic [ROW_W-1:0]      rd_row;
   logic [WB1-1:0]        rd_vp;
   logic [ROW_W-1:0]      row_eff;
   logic [WB1-1:0]        vp_eff;

   logic                  hit;
   logic [WB1-1:0]        hit_way;
   logic [WB1-1:0]        victim;
   logic [ROW_W-1:0]      new_row;
   logic [TAG_W-1:0]      sel_tag;
   logic [WB1-1:0]        res_way;
   logic [ENT_FW-1:0]     ent_full;

   // request decode
   always_comb begin
      cw_wide  = 64'(req.cache_word);
      req_tag  = req.guest_address[GUEST_ADDR_W-1 -: TAG_W];
      req_way  = WB1'(cw_wide >> (INDEX_BITS + PAGE_BITS)) & WAY_MASK;
      if (req.mode) begin
         req_index = req.cache_word[INDEX_BITS-1:0];
         req_page  = PAGE_BITS'(cw_wide >> INDEX_BITS);
      end else begin
         req_index = req.guest_address[INDEX_BITS:1];
         req_page  = req_tag[PAGE_BITS-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign finish   = (state_ff == ST_BUSY) && out_free;
   assign accept   = req.valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ptr_ff == PAGE_BITS'(NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (finish && !accept) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready  = 1'b0;
      clr_ptr_in = clr_ptr_ff;
      case (state_ff)
         ST_CLEAR: clr_ptr_in = clr_ptr_ff + PAGE_BITS'(1);
         ST_IDLE:  req_ready  = 1'b1;
         ST_BUSY:  req_ready  = out_free;
         default:  req_ready  = 1'b0;
      endcase
   end

   assign req.ready = req_ready;

   // memories: one row of way tags per page, one victim pointer per page
   assign row_eff = fwd_ff ? fwd_row_ff : rd_row;
   assign vp_eff  = fwd_ff ? fwd_vp_ff : rd_vp;

   tcl_match #(
      .WAY_BITS (WAY_BITS),
      .TAG_W    (TAG_W)
   ) u_match (
      .row     (row_eff),
      .vp      (vp_eff),
      .tag     (tag_ff),
      .sel_way (way_ff),
      .hit     (hit),
      .hit_way (hit_way),
      .victim  (victim),
      .new_row (new_row),
      .sel_tag (sel_tag)
   );

   assign lk_miss = finish && !mode_ff && !hit;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ptr_ff;
         tag_wdata = '0;
         vp_wdata  = '0;
      end else begin
         mem_we    = lk_miss;
         mem_waddr = page_ff;
         tag_wdata = new_row;
         vp_wdata  = victim;
      end
   end

   tcl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_PAGES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (tag_wdata),
      .rd_en   (accept),
      .rd_addr (req_page),
      .rd_data (rd_row)
   );

   tcl_ram #(
      .WIDTH (WB1),
      .DEPTH (NUM_PAGES)
   ) u_vp_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (vp_wdata),
      .rd_en   (accept),
      .rd_addr (req_page),
      .rd_data (rd_vp)
   );

   // a read on the same edge as a write-back of its page sees the old row
   assign fwd_in = accept ? (lk_miss && (req_page == page_ff)) : fwd_ff;

   // result
   always_comb begin
      res_way  = hit ? hit_way : victim;
      ent_full = {res_way, page_ff, index_ff};
      if (mode_ff) begin
         entry_in = '0;
         clear_in = 1'b0;
         addr_in  = {sel_tag, index_ff, 1'b0};
      end else begin
         entry_in = ENTRY_W'(64'(ent_full));
         clear_in = !hit;
         addr_in  = '0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req.mode;
         page_ff    <= req_page;
         index_ff   <= req_index;
         tag_ff     <= req_tag;
         way_ff     <= req_way;
         fwd_row_ff <= new_row;
         fwd_vp_ff  <= victim;
      end
      if (finish) begin
         entry_ff <= entry_in;
         clear_ff <= clear_in;
         addr_ff  <= addr_in;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.entry_word        = entry_ff;
   assign rsp.page_clear_needed = clear_ff;
   assign rsp.recovered_address = addr_ff;

   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req.ready)
      else $error("request accepted during clearing pass");

   a_accept_to_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_BUSY))
      else $error("accepted request not held for row read");

   a_write_source : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_CLEAR) || (finish && !mode_ff)))
      else $error("memory write outside clearing or lookup completion");

   a_result_slot_free : assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("completed request did not reach output register");

endmodule

// File: rtl/core/tcl_ram.sv
module tcl_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tcl_match.sv
module tcl_match #(
   parameter int WAY_BITS = 2,
   parameter int TAG_W    = 21,
   localparam int NUM_WAYS = 1 << WAY_BITS,
   localparam int WB1      = (WAY_BITS > 0) ? WAY_BITS : 1,
   localparam int ROW_W    = NUM_WAYS * TAG_W
) (
   input  logic [ROW_W-1:0] row,
   input  logic [WB1-1:0]   vp,
   input  logic [TAG_W-1:0] tag,
   input  logic [WB1-1:0]   sel_way,
   output logic             hit,
   output logic [WB1-1:0]   hit_way,
   output logic [WB1-1:0]   victim,
   output logic [ROW_W-1:0] new_row,
   output logic [TAG_W-1:0] sel_tag
);

   localparam logic [WB1-1:0] WAY_MASK = WB1'(NUM_WAYS - 1);

   // lowest matching way wins, so scan from the top down
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (row[w*TAG_W +: TAG_W] == tag) begin
            hit     = 1'b1;
            hit_way = WB1'(w);
         end
      end
   end

   always_comb begin
      victim  = (vp + WB1'(1)) & WAY_MASK;
      new_row = row;
      new_row[victim*TAG_W +: TAG_W] = tag;
      sel_tag = row[sel_way*TAG_W +: TAG_W];
   end

endmodule

// File: tb/tcl_tb_pkg.sv
`timescale 1ns / 100ps
package tcl_tb_pkg;

   typedef enum logic {
      MODE_LOOKUP  = 1'b0,
      MODE_REVERSE = 1'b1
   } lookup_mode_type;

endpackage

// File: tb/translation_cache_tag_lookup_check.sv
`timescale 1ns / 100ps
module translation_cache_tag_lookup_check import tcl_pkg::*; import tcl_tb_pkg::*; #(
   parameter int WAY_BITS   = 2,
   parameter int PAGE_BITS  = 9,
   parameter int INDEX_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   tcl_req_if   req,
   tcl_rsp_if   rsp,
   output int   mismatch_count,
   output int   outstanding
);

   localparam int NUM_WAYS  = 1 << WAY_BITS;
   localparam int NUM_PAGES = 1 << PAGE_BITS;
   localparam int TAG_W     = GUEST_ADDR_W - 1 - INDEX_BITS;

   typedef struct packed {
      logic [ENTRY_W-1:0]      entry_word;
      logic                    page_clear_needed;
      logic [GUEST_ADDR_W-1:0] recovered_address;
   } tag_result_type;

   logic [TAG_W-1:0]    tag_mem     [NUM_WAYS][NUM_PAGES];
   logic [WAY_BITS-1:0] last_victim [NUM_PAGES];
   tag_result_type      result_q    [$];

   // updates the tag copy on a miss, so call exactly once per accepted request
   function automatic tag_result_type predict_result(input logic mode,
                                                     input logic [GUEST_ADDR_W-1:0] addr,
                                                     input logic [CACHE_WORD_W-1:0] cw);
      tag_result_type        r;
      logic [TAG_W-1:0]      tag;
      logic [PAGE_BITS-1:0]  page;
      logic [INDEX_BITS-1:0] index;
      logic [WAY_BITS-1:0]   way;
      bit                    hit;
      r   = '0;
      hit = 1'b0;
      way = '0;
      if (mode == MODE_LOOKUP) begin
         index = addr[INDEX_BITS:1];
         tag   = addr[GUEST_ADDR_W-1:INDEX_BITS+1];
         page  = tag[PAGE_BITS-1:0];
         // walk downward so the lowest matching way wins
         for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (tag_mem[w][page] == tag) begin
               way = WAY_BITS'(w);
               hit = 1'b1;
            end
         end
         if (!hit) begin
            way = last_victim[page] + 1'b1;
            tag_mem[way][page] = tag;
            last_victim[page] = way;
         end
         r.entry_word        = ENTRY_W'({way, page, index});
         r.page_clear_needed = !hit;
      end else begin
         index = cw[INDEX_BITS-1:0];
         page  = cw[INDEX_BITS +: PAGE_BITS];
         way   = cw[INDEX_BITS+PAGE_BITS +: WAY_BITS];
         r.recovered_address = GUEST_ADDR_W'({tag_mem[way][page], index, 1'b0});
      end
      return r;
   endfunction

   always @(posedge clock) begin
      tag_result_type want;
      if (reset) begin
         for (int w = 0; w < NUM_WAYS; w++)
            for (int p = 0; p < NUM_PAGES; p++)
               tag_mem[w][p] = '0;
         for (int p = 0; p < NUM_PAGES; p++)
            last_victim[p] = '0;
         result_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (result_q.size() == 0) begin
               $error("result transaction with no request outstanding");
               mismatch_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp.entry_word !== want.entry_word) begin
                  $error("entry_word: expected %h, actual %h", want.entry_word, rsp.entry_word);
                  mismatch_count++;
               end
               if (rsp.page_clear_needed !== want.page_clear_needed) begin
                  $error("page_clear_needed: expected %b, actual %b",
                         want.page_clear_needed, rsp.page_clear_needed);
                  mismatch_count++;
               end
               if (rsp.recovered_address !== want.recovered_address) begin
                  $error("recovered_address: expected %h, actual %h",
                         want.recovered_address, rsp.recovered_address);
                  mismatch_count++;
               end
            end
         end
         if (req.valid && req.ready)
            result_q.push_back(predict_result(req.mode, req.guest_address, req.cache_word));
      end
      outstanding = result_q.size();
   end

endmodule

// File: tb/translation_cache_tag_lookup_unit_tb.sv
`timescale 1ns / 100ps
module translation_cache_tag_lookup_unit_tb;
   import tcl_pkg::*;
   import tcl_tb_pkg::*;

   localparam int WAY_BITS        = 2;
   localparam int PAGE_BITS       = 9;
   localparam int INDEX_BITS      = 10;
   localparam int UPPER_W         = GUEST_ADDR_W - 1 - INDEX_BITS - PAGE_BITS;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASE_ITEMS     = 510;
   localparam int POOL_REFRESH    = 300;
   localparam int DIRECTED_PAGE   = 5;
   localparam int UNTOUCHED_PAGE  = 300;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   outstanding;
   int   send_idle_pct  = 0;
   int   rsp_stall_pct  = 0;
   int   hold_off_asked = 0;

   logic [UPPER_W-1:0]   upper_pool [6];
   logic [PAGE_BITS-1:0] page_pool  [8];

   tcl_req_if req ();
   tcl_rsp_if rsp ();

   translation_cache_tag_lookup_unit #(
      .WAY_BITS   (WAY_BITS),
      .PAGE_BITS  (PAGE_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   translation_cache_tag_lookup_check #(
      .WAY_BITS   (WAY_BITS),
      .PAGE_BITS  (PAGE_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_tag_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .rsp            (rsp),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : rsp_drain
      int hold_off_done;
      hold_off_done = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_asked != hold_off_done) begin
            hold_off_done = hold_off_asked;
            rsp.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_req(input lookup_mode_type mode, input logic [GUEST_ADDR_W-1:0] addr,
                           input logic [CACHE_WORD_W-1:0] cw);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid         <= 1'b1;
      req.mode          <= mode;
      req.guest_address <= addr;
      req.cache_word    <= cw;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic refill_pools();
      foreach (upper_pool[i]) upper_pool[i] = UPPER_W'($urandom);
      foreach (page_pool[i]) page_pool[i] = PAGE_BITS'($urandom);
   endtask

   // mostly addresses that land on a few busy pages so hits, misses and evictions mix
   task automatic send_random_req();
      logic [GUEST_ADDR_W-1:0] addr;
      logic [CACHE_WORD_W-1:0] cw;
      if ($urandom_range(99) < 60) begin
         if ($urandom_range(99) < 75)
            addr = {upper_pool[$urandom_range(5)], page_pool[$urandom_range(7)],
                    INDEX_BITS'($urandom), 1'($urandom)};
         else
            addr = $urandom;
         send_req(MODE_LOOKUP, addr, CACHE_WORD_W'($urandom));
      end else begin
         if ($urandom_range(99) < 70)
            cw = {WAY_BITS'($urandom), page_pool[$urandom_range(7)], INDEX_BITS'($urandom)};
         else
            cw = CACHE_WORD_W'($urandom);
         send_req(MODE_REVERSE, $urandom, cw);
      end
   endtask

   initial begin : stimulus
      reset             = 1'b1;
      req.valid         = 1'b0;
      req.mode          = MODE_LOOKUP;
      req.guest_address = '0;
      req.cache_word    = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 36;
      rsp_stall_pct <= 52;

      // tag zero hits way 0 straight after reset
      send_req(MODE_LOOKUP, 32'h0000_0000, '0);
      send_req(MODE_LOOKUP, 32'h0000_0001, '1);
      send_req(MODE_LOOKUP, 32'hFFFF_FFFF, '0);
      send_req(MODE_LOOKUP, 32'hFFFF_FFFE, '0);
      send_req(MODE_LOOKUP, 32'h8000_0000, '0);
      // five misses on one page wrap the victim pointer round
      for (int k = 1; k <= 5; k++)
         send_req(MODE_LOOKUP, {UPPER_W'(k), PAGE_BITS'(DIRECTED_PAGE),
                                INDEX_BITS'(k * 37), 1'b0}, '0);
      send_req(MODE_LOOKUP, {UPPER_W'(4), PAGE_BITS'(DIRECTED_PAGE),
                             {INDEX_BITS{1'b1}}, 1'b1}, '0);
      send_req(MODE_LOOKUP, {UPPER_W'(3), PAGE_BITS'(DIRECTED_PAGE),
                             INDEX_BITS'(0), 1'b0}, '0);
      // evicted tag comes back as a miss
      send_req(MODE_LOOKUP, {UPPER_W'(1), PAGE_BITS'(DIRECTED_PAGE),
                             INDEX_BITS'(0), 1'b0}, '0);
      for (int w = 0; w < (1 << WAY_BITS); w++)
         send_req(MODE_REVERSE, '1, {WAY_BITS'(w), PAGE_BITS'(DIRECTED_PAGE),
                                     INDEX_BITS'(w * 255)});
      send_req(MODE_REVERSE, '0, '1);
      send_req(MODE_REVERSE, '1, '0);
      send_req(MODE_REVERSE, '0, {WAY_BITS'(2), PAGE_BITS'(UNTOUCHED_PAGE),
                                  {INDEX_BITS{1'b1}}});

      refill_pools();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % POOL_REFRESH == POOL_REFRESH - 1) refill_pools();
         send_random_req();
      end

      send_idle_pct = 52;
      rsp_stall_pct <= 36;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % POOL_REFRESH == POOL_REFRESH - 1) refill_pools();
         send_random_req();
      end

      // back-to-back with a long output stall first so the input side backs up
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_off_asked <= hold_off_asked + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % POOL_REFRESH == POOL_REFRESH - 1) refill_pools();
         send_random_req();
      end

      req.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
